/* sv/mrlg_pkg.sv */
package mrlg_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COS_BETA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_BETA = 3'd4;

	localparam logic [31:0] CELL_LEN_RST = 32'h0010_0000;  // 1.0 in Q12.20
	localparam logic signed [31:0] COS_RST = 32'sh0000_0000;
	localparam logic signed [31:0] SIN_RST = 32'sh4000_0000;  // 1.0 in Q1.30

	localparam logic signed [63:0] K2  = 64'sd2;
	localparam logic signed [63:0] K4  = 64'sd4;
	localparam logic signed [63:0] KM4 = -64'sd4;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	localparam int unsigned UCODE_LEN = 36;
	localparam int unsigned PC_W = $clog2(UCODE_LEN);
	localparam logic [PC_W-1:0] PC_LAST = PC_W'(UCODE_LEN - 1);

	typedef struct packed {
		logic signed [31:0] dx_frac;
		logic signed [31:0] dy_frac;
		logic signed [31:0] dz_frac;
		logic [31:0]        target_sq;
		logic [31:0]        weight;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [62:0]        target_sum;
		logic signed [63:0] grad_a;
		logic signed [63:0] grad_b;
		logic signed [63:0] grad_c;
		logic signed [63:0] grad_beta;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic [31:0]        cell_a;
		logic [31:0]        cell_b;
		logic [31:0]        cell_c;
		logic signed [31:0] cos_beta;
		logic signed [31:0] sin_beta;
	} cfg_t;

	typedef enum logic {OP_MUL, OP_ADD} op_t;

	typedef enum logic [1:0] {SH_0, SH_24, SH_28, SH_30} shift_t;

	typedef enum logic [4:0] {
		SRC_DX, SRC_DY, SRC_DZ, SRC_CA, SRC_CB, SRC_CC, SRC_COS, SRC_SIN,
		SRC_WT, SRC_NTQ, SRC_K2, SRC_K4, SRC_KM4,
		SRC_U, SRC_V, SRC_W, SRC_UW, SRC_D2, SRC_WR, SRC_Q, SRC_T,
		SRC_ACC_T, SRC_ACC_A, SRC_ACC_B, SRC_ACC_C, SRC_ACC_BETA
	} src_t;

	typedef enum logic [3:0] {
		DST_U, DST_V, DST_W, DST_UW, DST_D2, DST_WR, DST_Q, DST_T,
		DST_ACC_T, DST_ACC_A, DST_ACC_B, DST_ACC_C, DST_ACC_BETA
	} dst_t;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_t;

	typedef struct packed {
		op_t    op;
		src_t   sel_a;
		src_t   sel_b;
		shift_t shift;
		dst_t   dst;
	} uop_t;

	typedef struct packed {
		logic   capture;
		logic   mul_start;
		logic   mul_wr;
		logic   add_wr;
		logic   finish;
		src_t   sel_a;
		src_t   sel_b;
		shift_t shift;
		dst_t   dst;
	} ctl_t;

	function automatic uop_t mk(op_t op, src_t a, src_t b, shift_t sh, dst_t d);
		uop_t u;
		u.op    = op;
		u.sel_a = a;
		u.sel_b = b;
		u.shift = sh;
		u.dst   = d;
		return u;
	endfunction

	// one restraint: distance, residual, target term, then the four gradients
	function automatic uop_t ucode(logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_MUL, SRC_DX,  SRC_CA,  SH_24, DST_U);
			6'd1:  u = mk(OP_MUL, SRC_DY,  SRC_CB,  SH_24, DST_V);
			6'd2:  u = mk(OP_MUL, SRC_DZ,  SRC_CC,  SH_24, DST_W);
			6'd3:  u = mk(OP_MUL, SRC_U,   SRC_W,   SH_24, DST_UW);
			6'd4:  u = mk(OP_MUL, SRC_U,   SRC_U,   SH_24, DST_T);
			6'd5:  u = mk(OP_MUL, SRC_V,   SRC_V,   SH_24, DST_Q);
			6'd6:  u = mk(OP_ADD, SRC_T,   SRC_Q,   SH_0,  DST_D2);
			6'd7:  u = mk(OP_MUL, SRC_W,   SRC_W,   SH_24, DST_T);
			6'd8:  u = mk(OP_ADD, SRC_D2,  SRC_T,   SH_0,  DST_D2);
			6'd9:  u = mk(OP_MUL, SRC_UW,  SRC_COS, SH_30, DST_T);
			6'd10: u = mk(OP_MUL, SRC_T,   SRC_K2,  SH_0,  DST_T);
			6'd11: u = mk(OP_ADD, SRC_D2,  SRC_T,   SH_0,  DST_D2);
			6'd12: u = mk(OP_ADD, SRC_D2,  SRC_NTQ, SH_0,  DST_D2);  // D2 now holds r
			6'd13: u = mk(OP_MUL, SRC_WT,  SRC_D2,  SH_24, DST_WR);
			6'd14: u = mk(OP_MUL, SRC_WR,  SRC_D2,  SH_24, DST_T);
			6'd15: u = mk(OP_ADD, SRC_ACC_T, SRC_T, SH_0,  DST_ACC_T);
			6'd16: u = mk(OP_MUL, SRC_W,   SRC_COS, SH_30, DST_T);
			6'd17: u = mk(OP_ADD, SRC_U,   SRC_T,   SH_0,  DST_T);
			6'd18: u = mk(OP_MUL, SRC_DX,  SRC_T,   SH_28, DST_Q);
			6'd19: u = mk(OP_MUL, SRC_WR,  SRC_Q,   SH_24, DST_T);
			6'd20: u = mk(OP_MUL, SRC_T,   SRC_K4,  SH_0,  DST_T);
			6'd21: u = mk(OP_ADD, SRC_ACC_A, SRC_T, SH_0,  DST_ACC_A);
			6'd22: u = mk(OP_MUL, SRC_DY,  SRC_V,   SH_28, DST_Q);
			6'd23: u = mk(OP_MUL, SRC_WR,  SRC_Q,   SH_24, DST_T);
			6'd24: u = mk(OP_MUL, SRC_T,   SRC_K4,  SH_0,  DST_T);
			6'd25: u = mk(OP_ADD, SRC_ACC_B, SRC_T, SH_0,  DST_ACC_B);
			6'd26: u = mk(OP_MUL, SRC_U,   SRC_COS, SH_30, DST_T);
			6'd27: u = mk(OP_ADD, SRC_W,   SRC_T,   SH_0,  DST_T);
			6'd28: u = mk(OP_MUL, SRC_DZ,  SRC_T,   SH_28, DST_Q);
			6'd29: u = mk(OP_MUL, SRC_WR,  SRC_Q,   SH_24, DST_T);
			6'd30: u = mk(OP_MUL, SRC_T,   SRC_K4,  SH_0,  DST_T);
			6'd31: u = mk(OP_ADD, SRC_ACC_C, SRC_T, SH_0,  DST_ACC_C);
			6'd32: u = mk(OP_MUL, SRC_UW,  SRC_SIN, SH_30, DST_Q);
			6'd33: u = mk(OP_MUL, SRC_WR,  SRC_Q,   SH_24, DST_T);
			6'd34: u = mk(OP_MUL, SRC_T,   SRC_KM4, SH_0,  DST_T);
			6'd35: u = mk(OP_ADD, SRC_ACC_BETA, SRC_T, SH_0, DST_ACC_BETA);
			default: u = mk(OP_ADD, SRC_T, SRC_T, SH_0, DST_T);
		endcase
		return u;
	endfunction

endpackage

/* sv/mrlg_mul.sv */
module mrlg_mul import mrlg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  shift_t             shift,
	output logic               done,
	output logic signed [63:0] res,
	output logic               sat
);

	localparam logic [2:0] CNT_LAST_PP = 3'd3;
	localparam logic [2:0] CNT_LAST_ADD = 3'd4;
	localparam logic [2:0] CNT_FINAL = 3'd5;
	localparam logic [63:0] HALF_RANGE = 64'h8000_0000_0000_0000;

	logic               busy_q;
	logic [2:0]         cnt_q;
	logic               done_q;
	logic [63:0]        mag_a_q, mag_b_q;
	logic               neg_q;
	shift_t             sh_q;
	logic [63:0]        pp_q;
	logic [1:0]         pp_pos_q;
	logic [127:0]       acc_q;
	logic signed [63:0] res_q;
	logic               sat_q;

	logic [31:0]  half_a, half_b;
	logic [63:0]  prod;
	logic [1:0]   pos;
	logic [127:0] addend;
	logic [127:0] shifted;
	logic [63:0]  hi, lo;
	logic signed [63:0] fin_res;
	logic         fin_sat;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		half_a = cnt_q[1] ? mag_a_q[63:32] : mag_a_q[31:0];
		half_b = cnt_q[0] ? mag_b_q[63:32] : mag_b_q[31:0];
		prod   = 64'(half_a) * 64'(half_b);
		case (cnt_q[1:0])
			2'd0:    pos = 2'd0;
			2'd3:    pos = 2'd2;
			default: pos = 2'd1;
		endcase
		case (pp_pos_q)
			2'd0:    addend = {64'b0, pp_q};
			2'd1:    addend = {32'b0, pp_q, 32'b0};
			default: addend = {pp_q, 64'b0};
		endcase
	end

	// truncation toward zero happens on the magnitude
	always_comb begin
		case (sh_q)
			SH_24:   shifted = acc_q >> 24;
			SH_28:   shifted = acc_q >> 28;
			SH_30:   shifted = acc_q >> 30;
			default: shifted = acc_q;
		endcase
		hi = shifted[127:64];
		lo = shifted[63:0];
		if (neg_q) begin
			if (hi != 64'b0 || lo > HALF_RANGE) begin
				fin_res = S64_MIN;
				fin_sat = 1'b1;
			end else begin
				fin_res = 64'sd0 - $signed(lo);
				fin_sat = 1'b0;
			end
		end else begin
			if (hi != 64'b0 || lo[63]) begin
				fin_res = S64_MAX;
				fin_sat = 1'b1;
			end else begin
				fin_res = $signed(lo);
				fin_sat = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_FINAL);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == CNT_FINAL) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_a_q <= a[63] ? 64'd0 - 64'(a) : 64'(a);
			mag_b_q <= b[63] ? 64'd0 - 64'(b) : 64'(b);
			neg_q   <= a[63] ^ b[63];
			sh_q    <= shift;
			acc_q   <= 128'b0;
		end else if (busy_q) begin
			if (cnt_q <= CNT_LAST_PP) begin
				pp_q     <= prod;
				pp_pos_q <= pos;
			end
			if (cnt_q != 3'd0 && cnt_q <= CNT_LAST_ADD) begin
				acc_q <= acc_q + addend;
			end
			if (cnt_q == CNT_FINAL) begin
				res_q <= fin_res;
				sat_q <= fin_sat;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;

endmodule

/* sv/mrlg_seq.sv */
module mrlg_seq import mrlg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic mul_done,
	input  logic last,
	input  logic out_hold,
	output logic in_stall,
	output ctl_t ctl
);

	state_t          state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	uop_t            uop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		uop           = ucode(pc_q);
		state_d       = state_q;
		pc_d          = pc_q;
		in_stall      = 1'b1;
		ctl.capture   = 1'b0;
		ctl.mul_start = 1'b0;
		ctl.mul_wr    = 1'b0;
		ctl.add_wr    = 1'b0;
		ctl.finish    = 1'b0;
		ctl.sel_a     = uop.sel_a;
		ctl.sel_b     = uop.sel_b;
		ctl.shift     = uop.shift;
		ctl.dst       = uop.dst;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.capture = 1'b1;
					pc_d        = '0;
					state_d     = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (uop.op == OP_MUL) begin
					ctl.mul_start = 1'b1;
					state_d       = ST_WAIT;
				end else begin
					ctl.add_wr = 1'b1;
					if (pc_q == PC_LAST) begin
						state_d = ST_FINISH;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
			end
			ST_WAIT: begin
				if (mul_done) begin
					ctl.mul_wr = 1'b1;
					if (pc_q == PC_LAST) begin
						state_d = ST_FINISH;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = ST_ISSUE;
					end
				end
			end
			ST_FINISH: begin
				// a finished set waits while the previous result is still held
				if (!(last && out_hold)) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/mrlg_dp.sv */
module mrlg_dp import mrlg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  in_item_t  in_data,
	input  cfg_t      cfg,
	input  logic      out_stall,
	output logic      mul_done,
	output logic      last,
	output logic      out_hold,
	output logic      out_valid,
	output out_item_t out_data
);

	in_item_t           in_q;
	logic signed [63:0] u_q, v_q, w_q, uw_q, d2_q, wr_q, q_q, t_q;
	logic signed [63:0] acc_t_q, acc_a_q, acc_b_q, acc_c_q, acc_beta_q;
	logic               item_sat_q, sat_flag_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [63:0] opa, opb, ntq;
	logic signed [63:0] sum, add_res, wr_val;
	logic               add_ovf;
	logic signed [63:0] mul_res;
	logic               mul_sat;
	logic               sat_merged;

	mrlg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.a      (opa),
		.b      (opb),
		.shift  (ctl.shift),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	assign ntq = 64'sd0 - $signed({24'b0, in_q.target_sq, 8'b0});

	always_comb begin
		case (ctl.sel_a)
			SRC_DX:       opa = 64'(in_q.dx_frac);
			SRC_DY:       opa = 64'(in_q.dy_frac);
			SRC_DZ:       opa = 64'(in_q.dz_frac);
			SRC_CA:       opa = $signed({32'b0, cfg.cell_a});
			SRC_CB:       opa = $signed({32'b0, cfg.cell_b});
			SRC_CC:       opa = $signed({32'b0, cfg.cell_c});
			SRC_COS:      opa = 64'(cfg.cos_beta);
			SRC_SIN:      opa = 64'(cfg.sin_beta);
			SRC_WT:       opa = $signed({32'b0, in_q.weight});
			SRC_NTQ:      opa = ntq;
			SRC_K2:       opa = K2;
			SRC_K4:       opa = K4;
			SRC_KM4:      opa = KM4;
			SRC_U:        opa = u_q;
			SRC_V:        opa = v_q;
			SRC_W:        opa = w_q;
			SRC_UW:       opa = uw_q;
			SRC_D2:       opa = d2_q;
			SRC_WR:       opa = wr_q;
			SRC_Q:        opa = q_q;
			SRC_T:        opa = t_q;
			SRC_ACC_T:    opa = acc_t_q;
			SRC_ACC_A:    opa = acc_a_q;
			SRC_ACC_B:    opa = acc_b_q;
			SRC_ACC_C:    opa = acc_c_q;
			SRC_ACC_BETA: opa = acc_beta_q;
			default:      opa = '0;
		endcase
		case (ctl.sel_b)
			SRC_DX:       opb = 64'(in_q.dx_frac);
			SRC_DY:       opb = 64'(in_q.dy_frac);
			SRC_DZ:       opb = 64'(in_q.dz_frac);
			SRC_CA:       opb = $signed({32'b0, cfg.cell_a});
			SRC_CB:       opb = $signed({32'b0, cfg.cell_b});
			SRC_CC:       opb = $signed({32'b0, cfg.cell_c});
			SRC_COS:      opb = 64'(cfg.cos_beta);
			SRC_SIN:      opb = 64'(cfg.sin_beta);
			SRC_WT:       opb = $signed({32'b0, in_q.weight});
			SRC_NTQ:      opb = ntq;
			SRC_K2:       opb = K2;
			SRC_K4:       opb = K4;
			SRC_KM4:      opb = KM4;
			SRC_U:        opb = u_q;
			SRC_V:        opb = v_q;
			SRC_W:        opb = w_q;
			SRC_UW:       opb = uw_q;
			SRC_D2:       opb = d2_q;
			SRC_WR:       opb = wr_q;
			SRC_Q:        opb = q_q;
			SRC_T:        opb = t_q;
			SRC_ACC_T:    opb = acc_t_q;
			SRC_ACC_A:    opb = acc_a_q;
			SRC_ACC_B:    opb = acc_b_q;
			SRC_ACC_C:    opb = acc_c_q;
			SRC_ACC_BETA: opb = acc_beta_q;
			default:      opb = '0;
		endcase
	end

	// saturating add: overflow only when both signs agree and the sum's differs
	always_comb begin
		sum     = opa + opb;
		add_ovf = (opa[63] == opb[63]) && (sum[63] != opa[63]);
		if (add_ovf) begin
			add_res = opa[63] ? S64_MIN : S64_MAX;
		end else begin
			add_res = sum;
		end
		wr_val     = ctl.mul_wr ? mul_res : add_res;
		sat_merged = sat_flag_q | item_sat_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			in_q <= in_data;
		end
		if (ctl.mul_wr || ctl.add_wr) begin
			case (ctl.dst)
				DST_U:   u_q  <= wr_val;
				DST_V:   v_q  <= wr_val;
				DST_W:   w_q  <= wr_val;
				DST_UW:  uw_q <= wr_val;
				DST_D2:  d2_q <= wr_val;
				DST_WR:  wr_q <= wr_val;
				DST_Q:   q_q  <= wr_val;
				DST_T:   t_q  <= wr_val;
				default: ;
			endcase
		end
		if (ctl.finish && in_q.last) begin
			out_q.target_sum <= acc_t_q[63] ? 63'b0 : acc_t_q[62:0];
			out_q.grad_a     <= acc_a_q;
			out_q.grad_b     <= acc_b_q;
			out_q.grad_c     <= acc_c_q;
			out_q.grad_beta  <= acc_beta_q;
			out_q.saturated  <= sat_merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_t_q     <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			acc_c_q     <= '0;
			acc_beta_q  <= '0;
			item_sat_q  <= 1'b0;
			sat_flag_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish && in_q.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.capture) begin
				item_sat_q <= 1'b0;
			end else if ((ctl.mul_wr && mul_sat) || (ctl.add_wr && add_ovf)) begin
				item_sat_q <= 1'b1;
			end
			if (ctl.mul_wr || ctl.add_wr) begin
				case (ctl.dst)
					DST_ACC_T:    acc_t_q    <= wr_val;
					DST_ACC_A:    acc_a_q    <= wr_val;
					DST_ACC_B:    acc_b_q    <= wr_val;
					DST_ACC_C:    acc_c_q    <= wr_val;
					DST_ACC_BETA: acc_beta_q <= wr_val;
					default: ;
				endcase
			end
			if (ctl.finish) begin
				if (in_q.last) begin
					acc_t_q     <= '0;
					acc_a_q     <= '0;
					acc_b_q     <= '0;
					acc_c_q     <= '0;
					acc_beta_q  <= '0;
					sat_flag_q  <= 1'b0;
				end else begin
					sat_flag_q <= sat_merged;
				end
			end
		end
	end

	assign last      = in_q.last;
	assign out_hold  = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/monoclinic_restraint_lsq_gradient.sv */
// Each restraint runs 25 products on the one 32x32 multiplier (four partial
// products per 64-bit product) and 11 adds, then a finish step that closes the
// restraint; closing the last restraint of a set raises out_valid. A new restraint
// is accepted only once the previous one is closed; a set result still
// held by out_stall delays the close of the next set's last restraint.
// Reset: cell registers go to a = b = c = 1.0, cos 0, sin 1.0; sums and flag clear.
module monoclinic_restraint_lsq_gradient import mrlg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t cfg_q;
	ctl_t ctl;
	logic mul_done, last, out_hold;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_a   <= CELL_LEN_RST;
			cfg_q.cell_b   <= CELL_LEN_RST;
			cfg_q.cell_c   <= CELL_LEN_RST;
			cfg_q.cos_beta <= COS_RST;
			cfg_q.sin_beta <= SIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CELL_A:   cfg_q.cell_a   <= cfg_data;
				REG_CELL_B:   cfg_q.cell_b   <= cfg_data;
				REG_CELL_C:   cfg_q.cell_c   <= cfg_data;
				REG_COS_BETA: cfg_q.cos_beta <= $signed(cfg_data);
				REG_SIN_BETA: cfg_q.sin_beta <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	mrlg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mul_done (mul_done),
		.last     (last),
		.out_hold (out_hold),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	mrlg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.mul_done  (mul_done),
		.last      (last),
		.out_hold  (out_hold),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* dv/monoclinic_restraint_lsq_gradient_test.sv */
`timescale 1ns / 1ps

module monoclinic_restraint_lsq_gradient_test;
	import mrlg_pkg::*;

	typedef logic signed [63:0] fix64_t;

	localparam int SETTLE = 260;        // a little over one restraint's work
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 110;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_SIN_BETA + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

	// predicts the sums of one restraint set and holds them until they come out
	class lsq_sums_checker;
		logic [31:0] len_a, len_b, len_c;
		fix64_t cos_b, sin_b;
		fix64_t acc_t, acc_ga, acc_gb, acc_gc, acc_gbeta;
		bit set_sat, item_sat;
		out_item_t pending_sums[$];
		int unsigned errors, restraints, sets_checked, sat_sets;

		function new();
			len_a = CELL_LEN_RST;
			len_b = CELL_LEN_RST;
			len_c = CELL_LEN_RST;
			cos_b = sext32(COS_RST);
			sin_b = sext32(SIN_RST);
			clear_sums();
		endfunction

		function void clear_sums();
			acc_t = '0;
			acc_ga = '0;
			acc_gb = '0;
			acc_gc = '0;
			acc_gbeta = '0;
			set_sat = 0;
		endfunction

		function fix64_t sext32(logic [31:0] v);
			return {{32{v[31]}}, v};
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_CELL_A:   len_a = val;
				REG_CELL_B:   len_b = val;
				REG_CELL_C:   len_c = val;
				REG_COS_BETA: cos_b = sext32(val);
				REG_SIN_BETA: sin_b = sext32(val);
				default: ;
			endcase
		endfunction

		// exact product, shifted with truncation toward zero, clamped to 64 bits
		function fix64_t mul_shift(fix64_t x, fix64_t y, int unsigned sh);
			logic [63:0] mx, my;
			logic [127:0] prod;
			mx = x[63] ? ~x + 64'd1 : x;
			my = y[63] ? ~y + 64'd1 : y;
			prod = {64'd0, mx} * {64'd0, my};
			prod = prod >> sh;
			if (x[63] ^ y[63]) begin
				if (prod > 128'h8000_0000_0000_0000) begin
					item_sat = 1;
					return S64_MIN;
				end
				return ~prod[63:0] + 64'd1;
			end
			if (prod > 128'h7FFF_FFFF_FFFF_FFFF) begin
				item_sat = 1;
				return S64_MAX;
			end
			return prod[63:0];
		endfunction

		function fix64_t add_sat(fix64_t a, fix64_t b);
			logic [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64:63] == 2'b01) begin
				item_sat = 1;
				return S64_MAX;
			end
			if (s[64:63] == 2'b10) begin
				item_sat = 1;
				return S64_MIN;
			end
			return s[63:0];
		endfunction

		function void accumulate_restraint(in_item_t it);
			fix64_t dx, dy, dz, ntq, wt, u, v, w, uw, d2, r, wr, q;
			out_item_t sums;
			restraints++;
			dx = sext32(it.dx_frac);
			dy = sext32(it.dy_frac);
			dz = sext32(it.dz_frac);
			ntq = 64'd0 - {24'd0, it.target_sq, 8'd0};
			wt = {32'd0, it.weight};
			item_sat = 0;
			u = mul_shift(dx, {32'd0, len_a}, 24);
			v = mul_shift(dy, {32'd0, len_b}, 24);
			w = mul_shift(dz, {32'd0, len_c}, 24);
			uw = mul_shift(u, w, 24);
			d2 = add_sat(mul_shift(u, u, 24), mul_shift(v, v, 24));
			d2 = add_sat(d2, mul_shift(w, w, 24));
			d2 = add_sat(d2, mul_shift(mul_shift(uw, cos_b, 30), K2, 0));
			r = add_sat(d2, ntq);
			wr = mul_shift(wt, r, 24);
			acc_t = add_sat(acc_t, mul_shift(wr, r, 24));
			q = mul_shift(dx, add_sat(u, mul_shift(w, cos_b, 30)), 28);
			acc_ga = add_sat(acc_ga, mul_shift(mul_shift(wr, q, 24), K4, 0));
			q = mul_shift(dy, v, 28);
			acc_gb = add_sat(acc_gb, mul_shift(mul_shift(wr, q, 24), K4, 0));
			q = mul_shift(dz, add_sat(w, mul_shift(u, cos_b, 30)), 28);
			acc_gc = add_sat(acc_gc, mul_shift(mul_shift(wr, q, 24), K4, 0));
			q = mul_shift(uw, sin_b, 30);
			acc_gbeta = add_sat(acc_gbeta, mul_shift(mul_shift(wr, q, 24), KM4, 0));
			if (item_sat)
				set_sat = 1;
			if (it.last) begin
				sums.target_sum = acc_t[63] ? 63'd0 : acc_t[62:0];
				sums.grad_a = acc_ga;
				sums.grad_b = acc_gb;
				sums.grad_c = acc_gc;
				sums.grad_beta = acc_gbeta;
				sums.saturated = set_sat;
				pending_sums.push_back(sums);
				clear_sums();
			end
		endfunction

		function void check_sums(out_item_t got);
			out_item_t want;
			if (pending_sums.size() == 0) begin
				errors++;
				$error("result with no restraint set pending");
				return;
			end
			want = pending_sums.pop_front();
			sets_checked++;
			if (want.saturated)
				sat_sets++;
			if (got.target_sum !== want.target_sum) begin
				errors++;
				$error("target_sum: expected %0d, got %0d", want.target_sum, got.target_sum);
			end
			if (got.grad_a !== want.grad_a) begin
				errors++;
				$error("grad_a: expected %0d, got %0d", want.grad_a, got.grad_a);
			end
			if (got.grad_b !== want.grad_b) begin
				errors++;
				$error("grad_b: expected %0d, got %0d", want.grad_b, got.grad_b);
			end
			if (got.grad_c !== want.grad_c) begin
				errors++;
				$error("grad_c: expected %0d, got %0d", want.grad_c, got.grad_c);
			end
			if (got.grad_beta !== want.grad_beta) begin
				errors++;
				$error("grad_beta: expected %0d, got %0d", want.grad_beta, got.grad_beta);
			end
			if (got.saturated !== want.saturated) begin
				errors++;
				$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lsq_sums_checker sb = new();
	bit calm = 0;
	int hold_len = 0;
	int settings_used = 0;

	monoclinic_restraint_lsq_gradient u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_sums(out_data);
	end

	// receiver: random stall bursts, one long hold-off on request, none when calm
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
			end else begin
				n = calm ? 1 : $urandom_range(1, 30);
				out_stall <= 1'b0;
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic in_item_t pack_restraint(logic [31:0] dx, logic [31:0] dy,
			logic [31:0] dz, logic [31:0] tq, logic [31:0] wt, logic last);
		in_item_t it;
		it.dx_frac = dx;
		it.dy_frac = dy;
		it.dz_frac = dz;
		it.target_sq = tq;
		it.weight = wt;
		it.last = last;
		return it;
	endfunction

	function automatic logic [31:0] corner32();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] frac_diff();
		return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
	endfunction

	// mode 0: physically sized, 1: raw random bits, 2: field corners
	function automatic in_item_t rand_restraint(int mode);
		case (mode)
			0: return pack_restraint(frac_diff(), frac_diff(), frac_diff(),
				$urandom_range(0, 32'h0190_0000), $urandom_range(0, 32'h0400_0000), 1'b0);
			1: return pack_restraint($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), 1'b0);
			default: return pack_restraint(corner32(), corner32(), corner32(), corner32(),
				corner32(), 1'b0);
		endcase
	endfunction

	task automatic offer(in_item_t it);
		int bursts;
		if (!calm && $urandom_range(0, 3) == 0) begin
			// now and then chain bursts so the gap ends late in the block's work
			bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 40) : 1;
			in_valid <= 1'b0;
			repeat (bursts) repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.accumulate_restraint(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic load_cell(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] cosv, logic [31:0] sinv);
		write_reg(REG_CELL_A, a);
		write_reg(REG_CELL_B, b);
		write_reg(REG_CELL_C, c);
		write_reg(REG_COS_BETA, cosv);
		write_reg(REG_SIN_BETA, sinv);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_sets(int n);
		int left, len, mode;
		in_item_t it;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			// most sets stay in range so their sums are clean
			mode = ($urandom_range(0, 9) < 6) ? 0 : -1;
			for (int i = 0; i < len; i++) begin
				if (mode == 0)
					it = rand_restraint(0);
				else
					it = rand_restraint($urandom_range(0, 9) < 6 ? 0 :
						($urandom_range(0, 1) ? 1 : 2));
				it.last = (i == len - 1);
				offer(it);
			end
			left -= len;
		end
	endtask

	initial begin
		in_item_t it;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings_used = 1;

		// unit cell, right angle
		offer(pack_restraint(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
		offer(pack_restraint(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 1'b0));
		offer(pack_restraint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h1, 1'b1));
		offer(pack_restraint(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		offer(pack_restraint(32'h0400_0000, 32'hF800_0000, 32'h0200_0000, 32'h0000_4CCD,
			32'h0100_0000, 1'b1));
		offer(pack_restraint(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0, 1'b1));
		offer(pack_restraint(32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1, 1'b0));
		offer(pack_restraint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1));
		offer(pack_restraint(32'h1000_0000, 32'h0, 32'hF000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1));
		offer(pack_restraint(32'h0800_0000, 32'h0800_0000, 32'h0800_0000, 32'h0003_0000,
			32'h0200_0000, 1'b1));
		offer(pack_restraint(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h8000_0000,
			32'h8000_0000, 1'b0));
		offer(pack_restraint(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000,
			32'h00FF_FFFF, 1'b0));
		offer(pack_restraint(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1'b1));
		for (int i = 0; i < 7; i++) begin
			it = rand_restraint(2);
			it.last = (i == 6);
			offer(it);
		end
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_cell(32'd11010048, 32'd7602176, 32'd14680064, 32'hECCC_CCCD,
					32'd1024349700);
				1: load_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
					32'h8000_0000);
				2: begin
					// writes past the last register must be ignored
					write_reg(REG_SPARE, $urandom());
					write_reg(REG_TOP, $urandom());
					load_cell(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
				end
				4: load_cell($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				7: load_cell(CELL_LEN_RST, CELL_LEN_RST, CELL_LEN_RST, COS_RST, SIN_RST);
				default: load_cell($urandom_range(32'h0010_0000, 32'h0280_0000),
					$urandom_range(32'h0010_0000, 32'h0280_0000),
					$urandom_range(32'h0010_0000, 32'h0280_0000),
					32'($urandom_range(0, 32'h7000_0000)) - 32'h3800_0000,
					$urandom_range(32'h2000_0000, 32'h4000_0000));
			endcase
			calm = (ph == PHASES - 1);
			if (ph == 3) begin
				// stall the output for a long while and keep offering one-restraint sets
				hold_len = HOLD_CYCLES;
				for (int i = 0; i < 12; i++) begin
					it = rand_restraint(0);
					it.last = 1'b1;
					offer(it);
				end
				run_sets(PHASE_ITEMS - 12);
			end else begin
				run_sets(PHASE_ITEMS);
			end
			drain();
		end

		$display("%0d restraints in %0d checked sets over %0d cell settings",
			sb.restraints, sb.sets_checked, settings_used);
		$display("%0d sets flagged saturation; output held off %0d cycles once",
			sb.sat_sets, HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending_sums.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* monoclinic_restraint_lsq_gradient.f */
sv/mrlg_pkg.sv
sv/mrlg_mul.sv
sv/mrlg_seq.sv
sv/mrlg_dp.sv
sv/monoclinic_restraint_lsq_gradient.sv
dv/monoclinic_restraint_lsq_gradient_test.sv
